>>> design/ccnt_pkg.sv
// shared constants for the cycle count to time converter
// no dependencies
package ccnt_pkg;

  // counter and result widths
  localparam int unsigned CountW = 64;
  localparam int unsigned HalfW  = 32;

  // default width of the frequency register
  localparam int unsigned FreqWDefault = 34;

  // time scale factors, both fit in 30 bits
  localparam int unsigned ScaleW = 30;
  localparam logic [ScaleW-1:0] NsPerSec = 30'd1000000000;
  localparam logic [ScaleW-1:0] UsPerSec = 30'd1000000;

  // product of elapsed count and scale
  localparam int unsigned ProdW = CountW + ScaleW;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFreq  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCalib = 2'd2;

  // unit select codes
  localparam logic UnitNs = 1'b0;
  localparam logic UnitUs = 1'b1;

endpackage

>>> design/cycle_count_to_time.sv
// cycle count to time converter: subtract, two multiply stages, then 94 divider
// stages, one quotient bit each; one request per cycle while the output is not stalled; the whole pipeline
// holds while the output request is not taken
// reset clears the configuration registers and all stage valid bits
// depends on ccnt_pkg and ccnt_div
module cycle_count_to_time #(
  parameter int unsigned FreqW = ccnt_pkg::FreqWDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [ccnt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // counter_value [63:0], unit [64], zero pad
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // time_value [63:0]
);

  localparam int unsigned CW = ccnt_pkg::CountW;
  localparam int unsigned HW = ccnt_pkg::HalfW;
  localparam int unsigned SW = ccnt_pkg::ScaleW;
  localparam int unsigned PW = ccnt_pkg::ProdW;

  logic [CW-1:0]    base_q;
  logic [FreqW-1:0] freq_q;
  logic             calib_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      freq_q  <= '0;
      calib_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccnt_pkg::CfgBase:  base_q  <= cfg_wdata_i;
        ccnt_pkg::CfgFreq:  freq_q  <= cfg_wdata_i[FreqW-1:0];
        ccnt_pkg::CfgCalib: calib_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // global advance
  logic en, div_v;
  logic [CW-1:0] quo;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage a: elapsed count and scale
  logic          a_v_q;
  logic [CW-1:0] a_el_q;
  logic [SW-1:0] a_sc_q;
  // stage b: partial products
  logic               b_v_q;
  logic [HW+SW-1:0]   b_lo_q, b_hi_q;
  // stage c: full product
  logic          c_v_q;
  logic [PW-1:0] c_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= s_tvalid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_el_q   <= s_tdata[CW-1:0] - base_q;
      a_sc_q   <= (s_tdata[CW] == ccnt_pkg::UnitUs) ? ccnt_pkg::UsPerSec
                                                    : ccnt_pkg::NsPerSec;
      b_lo_q   <= a_el_q[HW-1:0] * a_sc_q;
      b_hi_q   <= a_el_q[CW-1:HW] * a_sc_q;
      c_prod_q <= {b_hi_q, {HW{1'b0}}} + {{(PW-HW-SW){1'b0}}, b_lo_q};
    end
  end

  // floor(elapsed * scale / freq), low bits kept
  ccnt_div #(
    .FreqW (FreqW),
    .NumW  (PW),
    .QuoW  (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .num_i   (c_prod_q),
    .den_i   (freq_q),
    .valid_o (div_v),
    .quo_o   (quo)
  );

  // zero result while uncalibrated or frequency unknown
  logic cal_ok;
  assign cal_ok   = calib_q && (freq_q != '0);
  assign m_tvalid = div_v;
  assign m_tdata  = cal_ok ? quo : '0;

  // checks
  a_zero_uncal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !cal_ok) |-> (m_tdata == '0))
    else $error("nonzero result while uncalibrated");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> ($stable(c_v_q) && $stable(a_v_q)))
    else $error("pipeline moved during stall");

endmodule

>>> design/ccnt_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on ccnt_pkg for default widths
module ccnt_div #(
  parameter int unsigned FreqW = ccnt_pkg::FreqWDefault,
  parameter int unsigned NumW  = ccnt_pkg::ProdW,
  parameter int unsigned QuoW  = ccnt_pkg::CountW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [FreqW-1:0] den_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o
);

  logic             v_q   [0:NumW];
  logic [NumW-1:0]  num_q [0:NumW];
  logic [FreqW:0]   rem_q [0:NumW];
  logic [QuoW-1:0]  quo_q [0:NumW];

  // stage zero is the divider input
  assign v_q[0]   = valid_i;
  assign num_q[0] = num_i;
  assign rem_q[0] = '0;
  assign quo_q[0] = '0;

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [FreqW:0] trial;
    logic           fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {rem_q[s][FreqW-1:0], num_q[s][NumW-1]};
    assign fits  = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= {num_q[s][NumW-2:0], 1'b0};
        rem_q[s+1] <= fits ? (trial - {1'b0, den_i}) : trial;
        quo_q[s+1] <= {quo_q[s][QuoW-2:0], fits};
      end
    end
  end

  assign valid_o = v_q[NumW];
  assign quo_o   = quo_q[NumW];

endmodule

>>> verif/cycle_count_to_time_tb.sv
// testbench for the cycle count to time converter: random and directed samples
// checked against a local predictor of elapsed time in ns or us
// depends on ccnt_pkg and the cycle_count_to_time rtl
`timescale 1ns / 1ps

module cycle_count_to_time_tb;

  localparam int unsigned FreqBits = 34;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  // elapsed time predictor and store of pending times
  class time_scoreboard;
    logic [63:0] base_q;
    logic [FreqBits-1:0] freq_q;
    logic calib_q;
    logic [63:0] pending_times[$];
    int unsigned mismatches;
    int unsigned checked;

    function void reset_regs();
      base_q = '0;
      freq_q = '0;
      calib_q = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [ccnt_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
      case (idx)
        ccnt_pkg::CfgBase: base_q = val;
        ccnt_pkg::CfgFreq: freq_q = val[FreqBits-1:0];
        ccnt_pkg::CfgCalib: calib_q = val[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] elapsed_time(logic [63:0] count, logic unit_sel);
      logic [63:0] scale;
      logic [63:0] elapsed;
      logic [63:0] f;
      if (!calib_q || freq_q == '0) return '0;
      scale = (unit_sel == ccnt_pkg::UnitUs) ? 64'd1000000 : 64'd1000000000;
      f = {30'd0, freq_q};
      elapsed = count - base_q;
      return (elapsed / f) * scale + ((elapsed % f) * scale) / f;
    endfunction

    function void note_sample(logic [63:0] count, logic unit_sel);
      pending_times.push_back(elapsed_time(count, unit_sel));
    endfunction

    function void check_time(logic [63:0] got);
      logic [63:0] want;
      checked++;
      if (pending_times.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_times.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("time mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [ccnt_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic s_tvalid, s_tready;
  logic [71:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [63:0] m_tdata;

  time_scoreboard sb;
  int unsigned sent;
  int unsigned idle_cycles;
  bit rx_idle_on;
  bit long_hold;
  bit timed_out;

  cycle_count_to_time dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // output side: check results, random stalls and a long hold
  initial begin
    int unsigned gap;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) sb.check_time(m_tdata);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        m_tready <= (gap == 0);
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted request
  initial begin
    timed_out = 1'b0;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one register write, then write enable is dropped
  task automatic write_cfg(logic [ccnt_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for all pending times, then let the pipeline settle
  task automatic drain();
    while (sb.pending_times.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // send one sample, holding valid until taken
  task automatic send_sample(logic [63:0] count, logic unit_sel, bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, unit_sel, count};
    do @(posedge clk_i); while (!s_tready);
    sb.note_sample(count, unit_sel);
    sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic idle_input();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random burst of samples around the base, with some wide counts
  task automatic random_burst(int unsigned n, bit gaps);
    logic [63:0] c;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: c = rand64();
        1: c = sb.base_q + {32'd0, $urandom()};
        2: c = sb.base_q - {48'd0, $urandom_range(0, 65535)};
        default: c = sb.base_q + {sb.freq_q, 4'd0} * $urandom_range(0, 1000);
      endcase
      send_sample(c, $urandom_range(0, 1), gaps);
    end
    idle_input();
  endtask

  initial begin
    logic [63:0] freqs[6];
    sb = new();
    sb.reset_regs();
    sent = 0;
    rx_idle_on = 1'b1;
    long_hold = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ccnt_pkg::CfgBase;
    cfg_wdata_i = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // not calibrated, frequency unknown
    send_sample('1, ccnt_pkg::UnitNs, 1'b0);
    send_sample('0, ccnt_pkg::UnitUs, 1'b0);
    idle_input();
    drain();
    // frequency set but still not calibrated, wide write drops upper bits
    write_cfg(ccnt_pkg::CfgFreq, 64'hFFFF_FFF0_0000_0001 | 64'd1000);
    write_cfg(ccnt_pkg::CfgBase, 64'd500);
    send_sample(64'd1500, ccnt_pkg::UnitNs, 1'b0);
    idle_input();
    drain();
    // calibrated with zero frequency, then unknown index ignored
    write_cfg(ccnt_pkg::CfgCalib, 64'hFFFF_FFFF_FFFF_FFFE | 64'd1);
    write_cfg(ccnt_pkg::CfgFreq, 64'd0);
    send_sample(64'd12345, ccnt_pkg::UnitNs, 1'b0);
    idle_input();
    drain();
    write_cfg(2'd3, 64'hDEAD);
    write_cfg(ccnt_pkg::CfgFreq, 64'd1000);
    // counter below base, extremes, large elapsed
    send_sample(64'd1500, ccnt_pkg::UnitNs, 1'b0);
    send_sample(64'd1500, ccnt_pkg::UnitUs, 1'b0);
    send_sample(64'd499, ccnt_pkg::UnitNs, 1'b0);
    send_sample(64'd0, ccnt_pkg::UnitUs, 1'b0);
    send_sample('1, ccnt_pkg::UnitNs, 1'b0);
    send_sample('1, ccnt_pkg::UnitUs, 1'b0);
    send_sample(64'h8000_0000_0000_0000, ccnt_pkg::UnitNs, 1'b0);
    idle_input();
    drain();
    write_cfg(ccnt_pkg::CfgFreq, 64'h3_FFFF_FFFF);
    write_cfg(ccnt_pkg::CfgBase, '1);
    send_sample('1, ccnt_pkg::UnitNs, 1'b0);
    send_sample(64'h3_FFFF_FFFE, ccnt_pkg::UnitNs, 1'b0);
    send_sample(64'h3_FFFF_FFFF, ccnt_pkg::UnitUs, 1'b0);
    send_sample(64'hAAAA_AAAA_AAAA_AAAA, ccnt_pkg::UnitNs, 1'b0);
    send_sample(64'h5555_5555_5555_5555, ccnt_pkg::UnitUs, 1'b0);
    idle_input();
    drain();
    write_cfg(ccnt_pkg::CfgFreq, 64'd1);
    write_cfg(ccnt_pkg::CfgBase, 64'd0);
    send_sample('1, ccnt_pkg::UnitNs, 1'b0);
    send_sample(64'd7, ccnt_pkg::UnitUs, 1'b0);
    idle_input();
    drain();

    // random phases over several settings
    freqs = '{64'd1, 64'd1000, 64'd100000000, 64'h3_FFFF_FFFF, 64'd3000000000, 64'd0};
    for (int p = 0; p < 12; p++) begin
      write_cfg(ccnt_pkg::CfgBase, rand64());
      write_cfg(ccnt_pkg::CfgFreq, (p % 4 == 3) ? {$urandom(), $urandom()} : freqs[p % 6]);
      write_cfg(ccnt_pkg::CfgCalib, (p == 5) ? 64'd0 : 64'd1);
      if (p == 2) long_hold = 1'b1;
      random_burst(80, 1'b1);
      // pause until all results are back
      drain();
    end
    // last part without idling
    rx_idle_on = 1'b0;
    write_cfg(ccnt_pkg::CfgFreq, 64'd24000000);
    random_burst(120, 1'b0);
    drain();

    $display("converted %0d samples across many register settings, incl. uncalibrated, zero",
             sent);
    $display("frequency, wrapping counts, ns and us units, with stalls on both sides");
    if (sb.mismatches == 0 && sb.pending_times.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
